FILE: rtl/ccr_pkg.sv
//------------------------------------------------------------------------------
// ccr_pkg
// Shared widths, latencies and constants of the cubic curve ribbon sampler.
//------------------------------------------------------------------------------
package ccr_pkg;

  localparam int COORD_FRAC_BITS = 16;

  localparam int CRD_W = 32;
  localparam int PC_W  = 13;
  localparam int IDX_W = 12;
  localparam logic [PC_W-1:0] PC_RESET = PC_W'(250);

  // Curve parameter u is unsigned Q1.24 and may reach exactly one.
  localparam int U_FRAC = 24;
  localparam int U_W    = U_FRAC + 1;

  // Power-form coefficients and partial sums stay below 2^38 in magnitude.
  localparam int COEF_W = 39;

  // Restoring divider: 64-bit dividend, 31-bit divisor, 32 quotient bits.
  localparam int DIV_W   = 32;
  localparam int DVS_W   = 31;
  localparam int DIV_LAT = DIV_W;

  // Square root of a 62-bit radicand, one root bit per stage.
  localparam int ROOT_W   = 31;
  localparam int SQRT_LAT = ROOT_W;

  localparam int CURVE_LAT = 7;

  // Chord magnitudes and their normalized form in [2^29, 2^30).
  localparam int MAG_W  = CRD_W + 1;
  localparam int NRM_W  = 30;
  localparam int NRM_HI = NRM_W - 1;

  // Base half width 0.03 in coordinate format.
  localparam int W_BASE = ((3 << COORD_FRAC_BITS) + 50) / 100;

  localparam int TOTAL_LAT = 2 + DIV_LAT + CURVE_LAT + 5 + SQRT_LAT + 2 + DIV_LAT + 1;

endpackage

FILE: rtl/cubic_curve_ribbon_sampler_unit.sv
//------------------------------------------------------------------------------
// cubic_curve_ribbon_sampler_unit
// Samples a cubic Bezier curve and the left ribbon offset at one index.
//------------------------------------------------------------------------------
// The unit takes one item on every clock cycle; busy never rises. Each item's
// result appears on the output ports, marked by done for one cycle, in the
// order the items were taken. The latency is set mainly by the 32-stage
// dividers (curve parameters, then offset scaling), the 7-stage curve
// evaluators and the 31-stage square root. The receiver cannot stall, so
// results must be taken as they come. point_count may be written only while
// no item is in flight.
module cubic_curve_ribbon_sampler_unit
  import ccr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    start,
  output logic                    busy,
  input  logic signed [CRD_W-1:0] start_x,
  input  logic signed [CRD_W-1:0] start_y,
  input  logic signed [CRD_W-1:0] first_ctrl_x,
  input  logic signed [CRD_W-1:0] first_ctrl_y,
  input  logic signed [CRD_W-1:0] second_ctrl_x,
  input  logic signed [CRD_W-1:0] second_ctrl_y,
  input  logic signed [CRD_W-1:0] end_x,
  input  logic signed [CRD_W-1:0] end_y,
  input  logic signed [CRD_W-1:0] stroke_width,
  input  logic [IDX_W-1:0]        sample_index,

  output logic                    done,
  output logic signed [CRD_W-1:0] mid_x,
  output logic signed [CRD_W-1:0] mid_y,
  output logic signed [CRD_W-1:0] left_off_x,
  output logic signed [CRD_W-1:0] left_off_y,
  output logic                    zero_chord,

  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [PC_W-1:0]         cfg_data
);

  typedef struct packed {
    logic signed [CRD_W-1:0] p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
  } pts_t;

  typedef struct packed {
    pts_t pts;
    logic izero;
    logic sneg;
  } side_a_t;

  typedef struct packed {
    logic [DIV_W-1:0] qw;
    logic             sneg;
    logic             izero;
  } side_b_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] midx;
    logic signed [CRD_W-1:0] midy;
    logic                    dxneg;
    logic                    dyneg;
    logic                    zero;
    logic [DIV_W-1:0]        wm;
    logic                    wneg;
  } keep_t;

  typedef struct packed {
    keep_t            keep;
    logic [NRM_W-1:0] nx;
    logic [NRM_W-1:0] ny;
  } side_c_t;

  typedef struct packed {
    keep_t keep;
    logic  ovfx;
    logic  ovfy;
  } side_d_t;

  function automatic logic signed [CRD_W-1:0] sat_off(input logic [DIV_W-1:0] q,
                                                      input logic neg);
    logic [CRD_W-1:0] r;
    if (!neg) begin
      r = q[DIV_W-1] ? {1'b0, {(CRD_W-1){1'b1}}} : q;
    end else begin
      r = (q > {1'b1, {(CRD_W-1){1'b0}}}) ? {1'b1, {(CRD_W-1){1'b0}}} : (~q + 1'b1);
    end
    return r;
  endfunction

  logic                  accept;
  logic [PC_W-1:0]       point_count;
  logic [TOTAL_LAT-1:0]  vld;

  // Stage 1: clamp the count and index, and take the stroke width magnitude.
  logic [PC_W-1:0]  n_c, m_c, i_c, j_c;
  logic [CRD_W-1:0] smag_c;
  pts_t             pts1;
  logic [PC_W-1:0]  j1, m1, n1;
  logic             izero1, sneg1;
  logic [CRD_W-1:0] smag1;

  // Stage 2: divider operands.
  logic [2*DIV_W-1:0] num_a2, num_b2, wnum2;
  logic [DVS_W-1:0]   m2, n2;
  side_a_t            side2;
  side_a_t            la [DIV_LAT];
  logic [DIV_W-1:0]   qa, qb, qw;

  side_b_t            lb [CURVE_LAT];
  logic signed [CRD_W-1:0] ax, ay, bx, by;

  // Stage 42: chord and half width.
  logic signed [MAG_W-1:0] dxs, dys;
  logic signed [CRD_W:0]   wq_s, w_s;
  keep_t                   keep42, keep43, keep44, keep45, keep46;
  logic [MAG_W-1:0]        mdx42, mdy42, mdx43, mdy43, big;
  logic [5:0]              pos;
  logic [1:0]              rsh_c, rsh43;
  logic [4:0]              lsh_c, lsh43;
  logic [NRM_W-1:0]        nx44, ny44, nx45, ny45, nx46, ny46;
  logic [2*NRM_W-1:0]      sqx45, sqy45;
  logic [2*NRM_W:0]        sum46;

  side_c_t                 lc [SQRT_LAT];
  logic [ROOT_W-1:0]       root;

  logic [DIV_W+NRM_W-1:0]  px78, py78;
  logic [ROOT_W-1:0]       len78;
  keep_t                   keep78, keep79;
  logic [2*DIV_W-1:0]      dsum_x, dsum_y, dvx79, dvy79;
  logic                    ovfx_c, ovfy_c, ovfx79, ovfy79;
  logic [DVS_W-1:0]        len79;

  side_d_t                 ld [DIV_LAT];
  logic [DIV_W-1:0]        qx, qy, offq_x, offq_y;
  side_d_t                 dlast;

  // The pipeline never stalls, so every start is taken.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= PC_RESET;
      vld         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        point_count <= cfg_data;
      end
      vld <= {vld[TOTAL_LAT-2:0], accept};
    end
  end

  assign done = vld[TOTAL_LAT-1];

  always_comb begin
    n_c    = (point_count < PC_W'(2)) ? PC_W'(2) : point_count;
    m_c    = n_c - 1'b1;
    i_c    = ({1'b0, sample_index} > m_c) ? m_c : {1'b0, sample_index};
    j_c    = (i_c == '0) ? PC_W'(1) : i_c;
    smag_c = stroke_width[CRD_W-1] ? (~stroke_width + 1'b1) : stroke_width;
  end

  always_ff @(posedge clk) begin
    pts1   <= '{start_x, start_y, first_ctrl_x, first_ctrl_y,
                second_ctrl_x, second_ctrl_y, end_x, end_y};
    j1     <= j_c;
    m1     <= m_c;
    n1     <= n_c;
    izero1 <= (i_c == '0);
    sneg1  <= stroke_width[CRD_W-1];
    smag1  <= smag_c;

    // Index zero borrows the chord of index one, which starts at u = 0.
    num_b2 <= (64'(j1) << U_FRAC) + 64'(m1 >> 1);
    num_a2 <= (64'(j1 - 1'b1) << U_FRAC) + 64'(m1 >> 1);
    wnum2  <= 64'(smag1) * 64'(j1) + 64'(n1 >> 1);
    m2     <= DVS_W'(m1);
    n2     <= DVS_W'(n1);
    side2  <= '{pts1, izero1, sneg1};
  end

  ccr_divider u_div_ua (.clk(clk), .dividend(num_a2), .divisor(m2), .quotient(qa));
  ccr_divider u_div_ub (.clk(clk), .dividend(num_b2), .divisor(m2), .quotient(qb));
  ccr_divider u_div_w  (.clk(clk), .dividend(wnum2),  .divisor(n2), .quotient(qw));

  always_ff @(posedge clk) begin
    la[0] <= side2;
    for (int k = 1; k < DIV_LAT; k++) begin
      la[k] <= la[k-1];
    end
    lb[0] <= '{qw, la[DIV_LAT-1].sneg, la[DIV_LAT-1].izero};
    for (int k = 1; k < CURVE_LAT; k++) begin
      lb[k] <= lb[k-1];
    end
  end

  ccr_curve u_curve_ax (.clk(clk),
    .p0(la[DIV_LAT-1].pts.p0x), .p1(la[DIV_LAT-1].pts.p1x),
    .p2(la[DIV_LAT-1].pts.p2x), .p3(la[DIV_LAT-1].pts.p3x),
    .u(qa[U_W-1:0]), .pt(ax));
  ccr_curve u_curve_ay (.clk(clk),
    .p0(la[DIV_LAT-1].pts.p0y), .p1(la[DIV_LAT-1].pts.p1y),
    .p2(la[DIV_LAT-1].pts.p2y), .p3(la[DIV_LAT-1].pts.p3y),
    .u(qa[U_W-1:0]), .pt(ay));
  ccr_curve u_curve_bx (.clk(clk),
    .p0(la[DIV_LAT-1].pts.p0x), .p1(la[DIV_LAT-1].pts.p1x),
    .p2(la[DIV_LAT-1].pts.p2x), .p3(la[DIV_LAT-1].pts.p3x),
    .u(qb[U_W-1:0]), .pt(bx));
  ccr_curve u_curve_by (.clk(clk),
    .p0(la[DIV_LAT-1].pts.p0y), .p1(la[DIV_LAT-1].pts.p1y),
    .p2(la[DIV_LAT-1].pts.p2y), .p3(la[DIV_LAT-1].pts.p3y),
    .u(qb[U_W-1:0]), .pt(by));

  always_comb begin
    dxs  = $signed({bx[CRD_W-1], bx}) - $signed({ax[CRD_W-1], ax});
    dys  = $signed({by[CRD_W-1], by}) - $signed({ay[CRD_W-1], ay});
    wq_s = $signed({1'b0, lb[CURVE_LAT-1].qw});
    w_s  = (CRD_W+1)'(W_BASE) + (lb[CURVE_LAT-1].sneg ? -wq_s : wq_s);
  end

  always_ff @(posedge clk) begin
    // At index zero the sample itself is the chord start, at u = 0.
    keep42.midx  <= lb[CURVE_LAT-1].izero ? ax : bx;
    keep42.midy  <= lb[CURVE_LAT-1].izero ? ay : by;
    keep42.dxneg <= dxs[MAG_W-1];
    keep42.dyneg <= dys[MAG_W-1];
    keep42.zero  <= (dxs == '0) && (dys == '0);
    keep42.wm    <= w_s[CRD_W] ? DIV_W'(-w_s) : DIV_W'(w_s);
    keep42.wneg  <= w_s[CRD_W];
    mdx42        <= dxs[MAG_W-1] ? MAG_W'(-dxs) : MAG_W'(dxs);
    mdy42        <= dys[MAG_W-1] ? MAG_W'(-dys) : MAG_W'(dys);
  end

  // Both magnitudes move together until the larger one has its top bit at 29.
  always_comb begin
    big = (mdx42 > mdy42) ? mdx42 : mdy42;
    pos = '0;
    for (int k = 0; k < MAG_W; k++) begin
      if (big[k]) begin
        pos = 6'(k);
      end
    end
    if (pos > 6'(NRM_HI)) begin
      rsh_c = 2'(pos - 6'(NRM_HI));
      lsh_c = '0;
    end else begin
      rsh_c = '0;
      lsh_c = 5'(6'(NRM_HI) - pos);
    end
  end

  always_ff @(posedge clk) begin
    keep43 <= keep42;
    mdx43  <= mdx42;
    mdy43  <= mdy42;
    rsh43  <= rsh_c;
    lsh43  <= lsh_c;

    keep44 <= keep43;
    nx44   <= NRM_W'((mdx43 >> rsh43) << lsh43);
    ny44   <= NRM_W'((mdy43 >> rsh43) << lsh43);

    keep45 <= keep44;
    nx45   <= nx44;
    ny45   <= ny44;
    sqx45  <= nx44 * nx44;
    sqy45  <= ny44 * ny44;

    keep46 <= keep45;
    nx46   <= nx45;
    ny46   <= ny45;
    sum46  <= {1'b0, sqx45} + {1'b0, sqy45};
  end

  ccr_isqrt u_isqrt (.clk(clk), .radicand({1'b0, sum46}), .root(root));

  always_ff @(posedge clk) begin
    lc[0] <= '{keep46, nx46, ny46};
    for (int k = 1; k < SQRT_LAT; k++) begin
      lc[k] <= lc[k-1];
    end
  end

  always_ff @(posedge clk) begin
    keep78 <= lc[SQRT_LAT-1].keep;
    px78   <= lc[SQRT_LAT-1].keep.wm * lc[SQRT_LAT-1].ny;
    py78   <= lc[SQRT_LAT-1].keep.wm * lc[SQRT_LAT-1].nx;
    len78  <= root;
  end

  // A quotient of 2^32 or more saturates; the divider then gets a zero.
  always_comb begin
    dsum_x = 64'(px78) + 64'(len78 >> 1);
    dsum_y = 64'(py78) + 64'(len78 >> 1);
    ovfx_c = dsum_x[2*DIV_W-1:DIV_W] >= {1'b0, len78};
    ovfy_c = dsum_y[2*DIV_W-1:DIV_W] >= {1'b0, len78};
  end

  always_ff @(posedge clk) begin
    keep79 <= keep78;
    dvx79  <= ovfx_c ? '0 : dsum_x;
    dvy79  <= ovfy_c ? '0 : dsum_y;
    ovfx79 <= ovfx_c;
    ovfy79 <= ovfy_c;
    len79  <= DVS_W'(len78);
  end

  ccr_divider u_div_ox (.clk(clk), .dividend(dvx79), .divisor(len79), .quotient(qx));
  ccr_divider u_div_oy (.clk(clk), .dividend(dvy79), .divisor(len79), .quotient(qy));

  always_ff @(posedge clk) begin
    ld[0] <= '{keep79, ovfx79, ovfy79};
    for (int k = 1; k < DIV_LAT; k++) begin
      ld[k] <= ld[k-1];
    end
  end

  assign dlast  = ld[DIV_LAT-1];
  assign offq_x = dlast.ovfx ? '1 : qx;
  assign offq_y = dlast.ovfy ? '1 : qy;

  // Left offset is (scaled dy, minus scaled dx).
  always_ff @(posedge clk) begin
    mid_x      <= dlast.keep.midx;
    mid_y      <= dlast.keep.midy;
    zero_chord <= dlast.keep.zero;
    left_off_x <= dlast.keep.zero ? '0 :
                  sat_off(offq_x, dlast.keep.wneg ^ dlast.keep.dyneg);
    left_off_y <= dlast.keep.zero ? '0 :
                  sat_off(offq_y, dlast.keep.wneg ^ ~dlast.keep.dxneg);
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##TOTAL_LAT done)
    else $error("item accepted without a result after the pipeline latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, TOTAL_LAT))
    else $error("result produced without a matching accepted item");

  a_zero_offsets: assert property (@(posedge clk) disable iff (rst)
    (done && zero_chord) |-> (left_off_x == '0 && left_off_y == '0))
    else $error("zero chord item carries a nonzero offset");

endmodule

FILE: rtl/ccr_divider.sv
//------------------------------------------------------------------------------
// ccr_divider
// Pipelined restoring divider, one quotient bit per stage. The upper half of
// the dividend must be below the divisor, so the quotient fits in 32 bits.
//------------------------------------------------------------------------------
module ccr_divider
  import ccr_pkg::*;
(
  input  logic                 clk,
  input  logic [2*DIV_W-1:0]   dividend,
  input  logic [DVS_W-1:0]     divisor,
  output logic [DIV_W-1:0]     quotient
);

  logic [DVS_W-1:0] rem_r  [DIV_LAT];
  logic [DIV_W-1:0] low_r  [DIV_LAT];
  logic [DIV_W-1:0] quo_r  [DIV_LAT];
  logic [DVS_W-1:0] dvs_r  [DIV_LAT];

  logic [DVS_W-1:0] rem_in [DIV_LAT];
  logic [DIV_W-1:0] low_in [DIV_LAT];
  logic [DIV_W-1:0] quo_in [DIV_LAT];
  logic [DVS_W-1:0] dvs_in [DIV_LAT];

  logic [DVS_W:0]   part   [DIV_LAT];
  logic [DVS_W:0]   diff   [DIV_LAT];
  logic             ge     [DIV_LAT];
  logic [DVS_W-1:0] rem_next [DIV_LAT];

  always_comb begin
    rem_in[0] = dividend[DIV_W +: DVS_W];
    low_in[0] = dividend[DIV_W-1:0];
    quo_in[0] = '0;
    dvs_in[0] = divisor;
    for (int k = 1; k < DIV_LAT; k++) begin
      rem_in[k] = rem_r[k-1];
      low_in[k] = low_r[k-1];
      quo_in[k] = quo_r[k-1];
      dvs_in[k] = dvs_r[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < DIV_LAT; k++) begin
      part[k]     = {rem_in[k], low_in[k][DIV_W-1]};
      diff[k]     = part[k] - {1'b0, dvs_in[k]};
      ge[k]       = part[k] >= {1'b0, dvs_in[k]};
      rem_next[k] = ge[k] ? diff[k][DVS_W-1:0] : part[k][DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_LAT; k++) begin
      rem_r[k] <= rem_next[k];
      low_r[k] <= {low_in[k][DIV_W-2:0], 1'b0};
      quo_r[k] <= {quo_in[k][DIV_W-2:0], ge[k]};
      dvs_r[k] <= dvs_in[k];
    end
  end

  assign quotient = quo_r[DIV_LAT-1];

endmodule

FILE: rtl/ccr_isqrt.sv
//------------------------------------------------------------------------------
// ccr_isqrt
// Pipelined floor square root of a 62-bit value, one root bit per stage.
//------------------------------------------------------------------------------
module ccr_isqrt
  import ccr_pkg::*;
(
  input  logic                  clk,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic [ROOT_W-1:0]     root
);

  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]    rem_r   [SQRT_LAT];
  logic [ROOT_W-1:0]   root_r  [SQRT_LAT];
  logic [2*ROOT_W-1:0] low_r   [SQRT_LAT];

  logic [REM_W-1:0]    rem_in  [SQRT_LAT];
  logic [ROOT_W-1:0]   root_in [SQRT_LAT];
  logic [2*ROOT_W-1:0] low_in  [SQRT_LAT];

  logic [REM_W+1:0]    part    [SQRT_LAT];
  logic [REM_W+1:0]    trial   [SQRT_LAT];
  logic [REM_W+1:0]    diff    [SQRT_LAT];
  logic                ge      [SQRT_LAT];

  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    low_in[0]  = radicand;
    for (int k = 1; k < SQRT_LAT; k++) begin
      rem_in[k]  = rem_r[k-1];
      root_in[k] = root_r[k-1];
      low_in[k]  = low_r[k-1];
    end
  end

  // Bring down the next two radicand bits and try to append a one to the root.
  always_comb begin
    for (int k = 0; k < SQRT_LAT; k++) begin
      part[k]  = {rem_in[k], low_in[k][2*ROOT_W-1 -: 2]};
      trial[k] = {2'b00, root_in[k], 2'b01};
      diff[k]  = part[k] - trial[k];
      ge[k]    = part[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQRT_LAT; k++) begin
      rem_r[k]  <= ge[k] ? diff[k][REM_W-1:0] : part[k][REM_W-1:0];
      root_r[k] <= {root_in[k][ROOT_W-2:0], ge[k]};
      low_r[k]  <= {low_in[k][2*ROOT_W-3:0], 2'b00};
    end
  end

  assign root = root_r[SQRT_LAT-1];

endmodule

FILE: rtl/ccr_curve.sv
//------------------------------------------------------------------------------
// ccr_curve
// Evaluates one coordinate of a cubic Bezier curve in power form with
// Horner steps, each product rounded half up to the coordinate format.
//------------------------------------------------------------------------------
module ccr_curve
  import ccr_pkg::*;
(
  input  logic                    clk,
  input  logic signed [CRD_W-1:0] p0,
  input  logic signed [CRD_W-1:0] p1,
  input  logic signed [CRD_W-1:0] p2,
  input  logic signed [CRD_W-1:0] p3,
  input  logic [U_W-1:0]          u,
  output logic signed [CRD_W-1:0] pt
);

  localparam logic signed [63:0] CRD_MAX = (64'sd1 <<< (CRD_W-1)) - 64'sd1;
  localparam logic signed [63:0] CRD_MIN = -(64'sd1 <<< (CRD_W-1));

  function automatic logic signed [63:0] rnd(input logic signed [63:0] x);
    return (x + (64'sd1 <<< (U_FRAC-1))) >>> U_FRAC;
  endfunction

  function automatic logic signed [CRD_W-1:0] sat(input logic signed [63:0] x);
    logic signed [CRD_W-1:0] r;
    if (x > CRD_MAX) begin
      r = CRD_MAX[CRD_W-1:0];
    end else if (x < CRD_MIN) begin
      r = CRD_MIN[CRD_W-1:0];
    end else begin
      r = x[CRD_W-1:0];
    end
    return r;
  endfunction

  logic signed [COEF_W-1:0] q0, q1, q2, q3;
  logic signed [COEF_W-1:0] b_c, e_c, c_c, d_c;

  logic signed [COEF_W-1:0] d1, c1, b1, a1;
  logic [U_W-1:0]           u1, u2, u3, u4, u5;
  logic signed [63:0]       m2, m4, m6;
  logic signed [COEF_W-1:0] c2, b2, a2, b3, a3, b4, a4, a5, a6;
  logic signed [COEF_W-1:0] t3, t5;
  logic signed [U_W:0]      us1, us3, us5;

  assign q0 = COEF_W'(p0);
  assign q1 = COEF_W'(p1);
  assign q2 = COEF_W'(p2);
  assign q3 = COEF_W'(p3);

  always_comb begin
    b_c = 3 * (q1 - q0);
    e_c = 3 * (q3 - q2);
    c_c = 3 * (q3 - q0) - 2 * b_c - e_c;
    d_c = 2 * (q0 - q3) + b_c + e_c;
  end

  assign us1 = {1'b0, u1};
  assign us3 = {1'b0, u3};
  assign us5 = {1'b0, u5};

  always_ff @(posedge clk) begin
    d1 <= d_c;
    c1 <= c_c;
    b1 <= b_c;
    a1 <= q0;
    u1 <= u;

    m2 <= d1 * us1;
    c2 <= c1;
    b2 <= b1;
    a2 <= a1;
    u2 <= u1;

    t3 <= COEF_W'(rnd(m2) + 64'(c2));
    b3 <= b2;
    a3 <= a2;
    u3 <= u2;

    m4 <= t3 * us3;
    b4 <= b3;
    a4 <= a3;
    u4 <= u3;

    t5 <= COEF_W'(rnd(m4) + 64'(b4));
    a5 <= a4;
    u5 <= u4;

    m6 <= t5 * us5;
    a6 <= a5;

    pt <= sat(rnd(m6) + 64'(a6));
  end

endmodule

FILE: sim/tb.sv
//------------------------------------------------------------------------------
// tb
// Testbench for the cubic curve ribbon sampler. Items are sent through the
// start/busy handshake with random gaps. Each result is checked against a
// predictor that evaluates the curve, the chord and the scaled offset in
// fixed point. point_count is swept through its extremes between phases.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import ccr_pkg::*;

  typedef struct {
    logic signed [CRD_W-1:0] px [4];
    logic signed [CRD_W-1:0] py [4];
    logic signed [CRD_W-1:0] width;
    logic [IDX_W-1:0]        index;
  } curve_item_t;

  typedef struct {
    logic signed [CRD_W-1:0] mx;
    logic signed [CRD_W-1:0] my;
    logic signed [CRD_W-1:0] lx;
    logic signed [CRD_W-1:0] ly;
    logic                    zc;
  } ribbon_pt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CRD_W-1:0] start_x = '0, start_y = '0;
  logic signed [CRD_W-1:0] first_ctrl_x = '0, first_ctrl_y = '0;
  logic signed [CRD_W-1:0] second_ctrl_x = '0, second_ctrl_y = '0;
  logic signed [CRD_W-1:0] end_x = '0, end_y = '0;
  logic signed [CRD_W-1:0] stroke_width = '0;
  logic [IDX_W-1:0]        sample_index = '0;
  logic                    done;
  logic signed [CRD_W-1:0] mid_x, mid_y, left_off_x, left_off_y;
  logic                    zero_chord;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [PC_W-1:0]         cfg_data = '0;

  ribbon_pt_t     expected_pts [$];
  logic [PC_W-1:0] model_count = PC_RESET;
  bit             failed = 0;
  bit             no_idle = 0;
  int             quiet_cycles = 0;
  bit             activity;

  localparam int WATCHDOG = 5000;

  always #5 clk = ~clk;

  cubic_curve_ribbon_sampler_unit u_top (.*);

  function automatic longint sat32(longint x);
    if (x > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (x < -64'sh80000000) return -64'sh80000000;
    return x;
  endfunction

  // floor((x + 2^23) / 2^24)
  function automatic longint round_u(longint x);
    return (x + (64'sd1 <<< (U_FRAC - 1))) >>> U_FRAC;
  endfunction

  function automatic longint curve_point(longint p0, longint p1, longint p2, longint p3,
                                         longint u);
    longint b, e, c, d, t;
    b = 3 * (p1 - p0);
    e = 3 * (p3 - p2);
    c = 3 * (p3 - p0) - 2 * b - e;
    d = 2 * (p0 - p3) + b + e;
    t = round_u(d * u) + c;
    t = round_u(t * u) + b;
    t = round_u(t * u) + p0;
    return sat32(t);
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit [63:0] mag(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint offset_part(bit [63:0] wm, bit wneg, bit [63:0] cm, bit cneg,
                                         bit [63:0] len);
    bit [63:0] q;
    longint r;
    q = (wm * cm + len / 2) / len;
    if (q > 64'hFFFFFFFF) q = 64'hFFFFFFFF;
    r = longint'(q);
    if (wneg != cneg) r = -r;
    return sat32(r);
  endfunction

  function automatic ribbon_pt_t ribbon_sample(curve_item_t it, logic [PC_W-1:0] count);
    ribbon_pt_t res;
    bit [63:0] n, m, i, j, ui, ua, ub, q, mdx, mdy, big, len, wm;
    longint ax, ay, bx, by, dx, dy, w, prod;
    n = count < 2 ? 64'd2 : 64'(count);
    m = n - 1;
    i = 64'(it.index);
    if (i > m) i = m;
    j = (i == 0) ? 64'd1 : i;
    ui = ((i << U_FRAC) + m / 2) / m;
    ua = (((j - 1) << U_FRAC) + m / 2) / m;
    ub = ((j << U_FRAC) + m / 2) / m;
    res.mx = CRD_W'(curve_point(it.px[0], it.px[1], it.px[2], it.px[3], longint'(ui)));
    res.my = CRD_W'(curve_point(it.py[0], it.py[1], it.py[2], it.py[3], longint'(ui)));
    ax = curve_point(it.px[0], it.px[1], it.px[2], it.px[3], longint'(ua));
    ay = curve_point(it.py[0], it.py[1], it.py[2], it.py[3], longint'(ua));
    bx = curve_point(it.px[0], it.px[1], it.px[2], it.px[3], longint'(ub));
    by = curve_point(it.py[0], it.py[1], it.py[2], it.py[3], longint'(ub));
    dx = bx - ax;
    dy = by - ay;
    if (dx == 0 && dy == 0) begin
      res.lx = '0;
      res.ly = '0;
      res.zc = 1'b1;
      return res;
    end
    prod = longint'(it.width) * longint'(j);
    q = (mag(prod) + n / 2) / n;
    w = longint'(W_BASE) + (prod < 0 ? -longint'(q) : longint'(q));
    mdx = mag(dx);
    mdy = mag(dy);
    big = mdx > mdy ? mdx : mdy;
    while (big >= (64'd1 << 30)) begin
      big >>= 1; mdx >>= 1; mdy >>= 1;
    end
    while (big < (64'd1 << 29)) begin
      big <<= 1; mdx <<= 1; mdy <<= 1;
    end
    len = floor_sqrt(mdx * mdx + mdy * mdy);
    wm = mag(w);
    res.lx = CRD_W'(offset_part(wm, w < 0, mdy, dy < 0, len));
    res.ly = CRD_W'(offset_part(wm, w < 0, mdx, !(dx < 0), len));
    res.zc = 1'b0;
    return res;
  endfunction

  // Result checker: the receiver cannot stall, so every done is a result.
  always @(posedge clk) begin
    ribbon_pt_t exp_pt;
    if (!rst && done) begin
      if (expected_pts.size() == 0) begin
        $error("unexpected result mid_x=%0d mid_y=%0d", mid_x, mid_y);
        failed = 1;
      end else begin
        exp_pt = expected_pts.pop_front();
        if (mid_x !== exp_pt.mx) begin
          $error("mid_x expected %0d actual %0d", exp_pt.mx, mid_x); failed = 1;
        end
        if (mid_y !== exp_pt.my) begin
          $error("mid_y expected %0d actual %0d", exp_pt.my, mid_y); failed = 1;
        end
        if (left_off_x !== exp_pt.lx) begin
          $error("left_off_x expected %0d actual %0d", exp_pt.lx, left_off_x); failed = 1;
        end
        if (left_off_y !== exp_pt.ly) begin
          $error("left_off_y expected %0d actual %0d", exp_pt.ly, left_off_y); failed = 1;
        end
        if (zero_chord !== exp_pt.zc) begin
          $error("zero_chord expected %0b actual %0b", exp_pt.zc, zero_chord); failed = 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    activity = (start && !busy) || done || (cfg_valid && cfg_ready);
    if (rst || activity) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(curve_item_t it);
    while (!no_idle && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    start_x <= it.px[0];       start_y <= it.py[0];
    first_ctrl_x <= it.px[1];  first_ctrl_y <= it.py[1];
    second_ctrl_x <= it.px[2]; second_ctrl_y <= it.py[2];
    end_x <= it.px[3];         end_y <= it.py[3];
    stroke_width <= it.width;
    sample_index <= it.index;
    do @(posedge clk); while (busy);
    expected_pts.push_back(ribbon_sample(it, model_count));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_pts.size() != 0) @(posedge clk);
  endtask

  task automatic set_point_count(logic [PC_W-1:0] value);
    drain();
    repeat (TOTAL_LAT + 8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    model_count = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [CRD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0: return 32'sh7FFFFFFF;
      1: return -32'sh80000000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(20'hFFFFF))) - 32'sh80000;
    endcase
  endfunction

  function automatic curve_item_t rand_item();
    curve_item_t it;
    int pick;
    logic [PC_W-1:0] n;
    pick = $urandom_range(19);
    for (int k = 0; k < 4; k++) begin
      it.px[k] = rand_coord();
      it.py[k] = rand_coord();
    end
    // Degenerate curves with all points equal give a zero chord.
    if (pick == 0) begin
      for (int k = 1; k < 4; k++) begin
        it.px[k] = it.px[0];
        it.py[k] = it.py[0];
      end
    end
    it.width = ($urandom_range(3) == 0) ? $urandom : rand_coord();
    n = model_count < 2 ? PC_W'(2) : model_count;
    if (pick == 1) it.index = IDX_W'($urandom);
    else if (pick == 2) it.index = '0;
    else it.index = IDX_W'($urandom_range(32'(n) - 1));
    return it;
  endfunction

  task automatic run_random(int count);
    for (int k = 0; k < count; k++) send_item(rand_item());
  endtask

  task automatic test_directed();
    curve_item_t it;
    logic signed [CRD_W-1:0] ext [4] = '{32'sh7FFFFFFF, -32'sh80000000, 32'sh0, 32'sh10000};
    for (int k = 0; k < 4; k++) begin
      it.px[k] = 32'sh10000 * k;
      it.py[k] = -32'sh8000 * k * k;
    end
    it.width = 32'sh10000;
    // Index zero, the last index and indices past the end.
    foreach (ext[e]) begin
      it.index = (e == 0) ? 12'd0 : (e == 1) ? 12'd249 : (e == 2) ? 12'd250 : 12'hFFF;
      send_item(it);
    end
    it.index = 12'd100;
    it.width = -32'sh80000000; send_item(it);
    it.width = 32'sh7FFFFFFF;  send_item(it);
    it.width = '0;             send_item(it);
    // Extreme coordinates saturate.
    for (int a = 0; a < 4; a++) begin
      for (int k = 0; k < 4; k++) begin
        it.px[k] = ext[(a + k) % 4];
        it.py[k] = ext[(a + 3 * k) % 4];
      end
      it.index = 12'(a * 60);
      send_item(it);
    end
    // A point curve gives a zero chord.
    for (int k = 0; k < 4; k++) begin
      it.px[k] = 32'sh12345;
      it.py[k] = -32'sh777;
    end
    it.index = 12'd0;  send_item(it);
    it.index = 12'd77; send_item(it);
  endtask

  task automatic test_count_sweep();
    logic [PC_W-1:0] counts [8] = '{13'd2, 13'd0, 13'd1, 13'd3, 13'd4096, 13'd8191,
                                   13'd17, 13'd250};
    foreach (counts[c]) begin
      set_point_count(counts[c]);
      run_random(40);
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 10; p++) begin
      set_point_count(PC_W'($urandom_range(2, 300)));
      no_idle = (p == 4);
      run_random(120);
    end
    no_idle = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_count_sweep();
    test_random();
    drain();
    repeat (TOTAL_LAT + 8) @(posedge clk);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
